@@ src/bcc_pkg.sv @@
// Package with the shared types and field widths of the bounded composition counter.
`timescale 1ns / 1ps

package bcc_pkg;

    // Widths of the stream fields and of the configuration register.
    localparam int unsigned BOUND_W  = 8;
    localparam int unsigned TARGET_W = 8;
    localparam int unsigned COUNT_W  = 64;

    // Sequencer states, one-hot.
    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_PREFIX = 4'b0010,
        ST_WINDOW = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    // What the coefficient memory currently stands for.
    typedef enum logic [1:0] {
        TAB_UNIT = 2'd0,  // polynomial 1, memory contents ignored
        TAB_ZERO = 2'd1,  // all-zero polynomial, memory contents ignored
        TAB_MEM  = 2'd2   // memory contents are valid
    } tab_mode_t;

endpackage

@@ src/bounded_composition_count_genfunc_top.sv @@
// Top level of the bounded composition counter with its two table memories.
`timescale 1ns / 1ps

// A non-empty box over a non-zero table gives its result after a prefix pass and a window pass
// over the table and the load of the output register; an empty box, or any item on an all-zero
// table, goes straight to the output register, which holds a stalled result until it is taken.
// One item is in work at a time: no new item is taken until its result is loaded for output.
// Reset (aresetn, synchronous, active low) clears the control state and sets the table to 1.

module bounded_composition_count_genfunc_top
    import bcc_pkg::*;
#(
    parameter int unsigned MAX_SUM = 255
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration: target_sum.
    input  logic                  cfg_wen,
    input  logic [TARGET_W-1:0]   cfg_wdata,
    // Input stream.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [2*BOUND_W-1:0]  s_tdata,   // [7:0] lower_bound, [15:8] upper_bound
    input  logic [0:0]            s_tuser,   // [0] first_variable
    // Result stream.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [COUNT_W-1:0]    m_tdata    // [63:0] way_count
);

    // Table geometry follows from the highest degree kept.
    localparam int unsigned DEPTH = MAX_SUM + 1;
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    // Width that holds both a table index and an input bound, plus one bit of headroom.
    localparam int unsigned CW    = ((AW > BOUND_W) ? AW : BOUND_W) + 1;

    // The two memories: the coefficient table and the prefix scratch.
    logic [COUNT_W-1:0] coef_mem [DEPTH];
    logic [COUNT_W-1:0] pfx_mem  [DEPTH];

    // Control registers.
    state_t             state_reg,    state_next;
    tab_mode_t          tab_mode_reg, tab_mode_next;
    logic [TARGET_W-1:0] target_sum_reg;
    logic               issue_on_reg, issue_on_next;
    logic               s1_vld_reg,   s1_vld_next;
    logic               m_tvalid_reg, m_tvalid_next;

    // Datapath registers.
    logic [AW-1:0]      cnt_reg,      cnt_next;
    logic [AW-1:0]      s1_addr_reg,  s1_addr_next;
    logic               s1_last_reg,  s1_last_next;
    logic               s1_top_reg,   s1_top_next;
    logic               s1_below_reg, s1_below_next;
    logic [BOUND_W-1:0] lo_reg,       lo_next;
    logic [BOUND_W-1:0] hi_reg,       hi_next;
    logic [COUNT_W-1:0] run_reg,      run_next;
    logic [COUNT_W-1:0] res_reg,      res_next;
    logic [COUNT_W-1:0] m_tdata_reg,  m_tdata_next;

    // Memory ports.
    logic               coef_we;
    logic [AW-1:0]      coef_waddr, coef_raddr;
    logic [COUNT_W-1:0] coef_wdata, coef_rdata;
    logic               pfx_we;
    logic [AW-1:0]      pfx_waddr, pfx_raddr_a, pfx_raddr_b;
    logic [COUNT_W-1:0] pfx_wdata, pfx_rdata_a, pfx_rdata_b;

    // Helper values.
    logic [CW-1:0]      cnt_ext, lo_ext, hi_ext, tgt_ext, top_idx, below_idx;
    logic [AW-1:0]      tgt_idx;
    logic [BOUND_W-1:0] in_lo, in_hi;
    logic               in_first;
    tab_mode_t          mode_eff;
    logic [COUNT_W-1:0] old_coef, win_val;

    assign in_lo    = s_tdata[BOUND_W-1:0];
    assign in_hi    = s_tdata[2*BOUND_W-1:BOUND_W];
    assign in_first = s_tuser[0];

    assign cnt_ext   = {{(CW-AW){1'b0}}, cnt_reg};
    assign lo_ext    = {{(CW-BOUND_W){1'b0}}, lo_reg};
    assign hi_ext    = {{(CW-BOUND_W){1'b0}}, hi_reg};
    assign tgt_ext   = {{(CW-TARGET_W){1'b0}}, target_sum_reg};
    assign top_idx   = cnt_ext - lo_ext;
    assign below_idx = cnt_ext - hi_ext - CW'(1);

    // A target beyond the table reports the highest kept degree.
    assign tgt_idx = (tgt_ext > CW'(MAX_SUM)) ? AW'(MAX_SUM) : tgt_ext[AW-1:0];

    // While the table stands for the polynomial 1, the memory is bypassed.
    assign old_coef = (tab_mode_reg == TAB_UNIT)
                    ? ((s1_addr_reg == '0) ? COUNT_W'(1) : '0)
                    : coef_rdata;

    // New coefficient: old[s-lo] + ... + old[s-hi] as a difference of two prefix sums.
    assign win_val = !s1_top_reg   ? '0 :
                     s1_below_reg  ? (pfx_rdata_a - pfx_rdata_b) : pfx_rdata_a;

    assign mode_eff = in_first ? TAB_UNIT : tab_mode_reg;

    always_comb begin
        state_next    = state_reg;
        tab_mode_next = tab_mode_reg;
        issue_on_next = issue_on_reg;
        s1_vld_next   = 1'b0;
        s1_addr_next  = cnt_reg;
        s1_last_next  = (cnt_reg == AW'(MAX_SUM));
        s1_top_next   = (cnt_ext >= lo_ext);
        s1_below_next = (cnt_ext > hi_ext);
        cnt_next      = cnt_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        run_next      = run_reg;
        res_next      = res_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;

        coef_we     = 1'b0;
        coef_waddr  = s1_addr_reg;
        coef_wdata  = win_val;
        coef_raddr  = cnt_reg;
        pfx_we      = 1'b0;
        pfx_waddr   = s1_addr_reg;
        pfx_wdata   = run_reg + old_coef;
        pfx_raddr_a = top_idx[AW-1:0];
        pfx_raddr_b = below_idx[AW-1:0];

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    lo_next = in_lo;
                    hi_next = in_hi;
                    if (in_lo > in_hi) begin
                        // Empty box: the product vanishes.
                        tab_mode_next = TAB_ZERO;
                        res_next      = '0;
                        state_next    = ST_FINISH;
                    end else if (mode_eff == TAB_ZERO) begin
                        res_next   = '0;
                        state_next = ST_FINISH;
                    end else begin
                        tab_mode_next = mode_eff;
                        cnt_next      = '0;
                        issue_on_next = 1'b1;
                        run_next      = '0;
                        state_next    = ST_PREFIX;
                    end
                end
            end
            ST_PREFIX: begin
                s1_vld_next = issue_on_reg;
                if (issue_on_reg) begin
                    if (cnt_reg == AW'(MAX_SUM)) begin
                        issue_on_next = 1'b0;
                    end else begin
                        cnt_next = cnt_reg + AW'(1);
                    end
                end
                if (s1_vld_reg) begin
                    pfx_we   = 1'b1;
                    run_next = run_reg + old_coef;
                    if (s1_last_reg) begin
                        cnt_next      = '0;
                        issue_on_next = 1'b1;
                        state_next    = ST_WINDOW;
                    end
                end
            end
            ST_WINDOW: begin
                s1_vld_next = issue_on_reg;
                if (issue_on_reg) begin
                    if (cnt_reg == AW'(MAX_SUM)) begin
                        issue_on_next = 1'b0;
                    end else begin
                        cnt_next = cnt_reg + AW'(1);
                    end
                end
                if (s1_vld_reg) begin
                    coef_we = 1'b1;
                    if (s1_addr_reg == tgt_idx) begin
                        res_next = win_val;
                    end
                    if (s1_last_reg) begin
                        tab_mode_next = TAB_MEM;
                        state_next    = ST_FINISH;
                    end
                end
            end
            ST_FINISH: begin
                // Hold the result until the output register is free.
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = res_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            tab_mode_reg   <= TAB_UNIT;
            target_sum_reg <= '0;
            issue_on_reg   <= 1'b0;
            s1_vld_reg     <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg    <= state_next;
            tab_mode_reg <= tab_mode_next;
            issue_on_reg <= issue_on_next;
            s1_vld_reg   <= s1_vld_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wen) begin
                target_sum_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg      <= cnt_next;
        s1_addr_reg  <= s1_addr_next;
        s1_last_reg  <= s1_last_next;
        s1_top_reg   <= s1_top_next;
        s1_below_reg <= s1_below_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        run_reg      <= run_next;
        res_reg      <= res_next;
        m_tdata_reg  <= m_tdata_next;
    end

    // Coefficient memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (coef_we) begin
            coef_mem[coef_waddr] <= coef_wdata;
        end
        coef_rdata <= coef_mem[coef_raddr];
    end

    // Prefix scratch memory: one write port, two registered read ports.
    always_ff @(posedge aclk) begin
        if (pfx_we) begin
            pfx_mem[pfx_waddr] <= pfx_wdata;
        end
        pfx_rdata_a <= pfx_mem[pfx_raddr_a];
        pfx_rdata_b <= pfx_mem[pfx_raddr_b];
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

@@ src/bcc_checker.sv @@
// Port-level checker for the bounded composition counter and its bind statement.
`timescale 1ns / 1ps

module bcc_checker
    import bcc_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_tvalid,
    input logic               s_tready,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [COUNT_W-1:0] m_tdata
);

    // A stalled result keeps its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Only one item is in work: the input closes after each transaction.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while one is in work");

    // A new result appears only at the end of a computation.
    a_result_after_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared while idle");

    // The input reopens only together with the result that it delivered.
    a_reopen_with_result: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(s_tready) |-> m_tvalid)
        else $error("input reopened without a result");

endmodule

bind bounded_composition_count_genfunc_top bcc_checker u_bcc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ dv/tb.sv @@
// Self-checking testbench for the bounded composition counter top level.
`timescale 1ns / 1ps

module tb;
    import bcc_pkg::*;

    localparam int unsigned MAX_SUM      = 255;
    localparam int          RANDOM_ITEMS = 1150;
    localparam int          CYCLE_LIMIT  = 4_000_000;
    localparam int          IDLE_GAP     = 3;

    typedef struct packed {
        logic [BOUND_W-1:0] lower_bound;
        logic [BOUND_W-1:0] upper_bound;
        logic               first_variable;
    } box_item_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_wen   = 1'b0;
    logic [TARGET_W-1:0]  cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [2*BOUND_W-1:0] s_tdata   = '0;   // [7:0] lower_bound, [15:8] upper_bound
    logic [0:0]           s_tuser   = '0;   // [0] first_variable
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [COUNT_W-1:0]   m_tdata;          // [63:0] way_count

    bounded_composition_count_genfunc_top #(
        .MAX_SUM   (MAX_SUM)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Boxes waiting to be sent, and the way counts the table model predicts for accepted ones.
    box_item_t          box_queue[$];
    logic [COUNT_W-1:0] way_count_queue[$];

    // Shadow copy of the generating-function table and of the target register.
    logic [COUNT_W-1:0]  coef_model [0:MAX_SUM];
    logic [TARGET_W-1:0] target_model = '0;

    int  error_count   = 0;
    int  cycle_count   = 0;
    int  items_queued  = 0;
    int  items_sent    = 0;
    int  results_seen  = 0;
    int  restarts_seen = 0;
    int  empty_boxes   = 0;
    int  targets_used  = 0;
    logic s_hs_seen    = 1'b0;
    logic m_hs_seen    = 1'b0;

    // Multiplies the model table by the box z^lo + ... + z^hi and returns the target coefficient.
    function automatic logic [COUNT_W-1:0] fold_box_into_table(input logic [BOUND_W-1:0] lo,
                                                              input logic [BOUND_W-1:0] hi,
                                                              input logic restart);
        logic [COUNT_W-1:0] psum [0:MAX_SUM];
        logic [COUNT_W-1:0] run_sum;
        logic [COUNT_W-1:0] v;
        int unsigned        deg;
        if (restart) begin
            for (int s = 0; s <= MAX_SUM; s++) coef_model[s] = '0;
            coef_model[0] = COUNT_W'(1);
        end
        if (lo > hi) begin
            for (int s = 0; s <= MAX_SUM; s++) coef_model[s] = '0;
        end else begin
            run_sum = '0;
            for (int s = 0; s <= MAX_SUM; s++) begin
                run_sum = run_sum + coef_model[s];
                psum[s] = run_sum;
            end
            // New entry at s is the sum of old entries s-hi .. s-lo.
            for (int s = 0; s <= MAX_SUM; s++) begin
                v = '0;
                if (s >= lo) begin
                    v = psum[s - lo];
                    if (s > hi) v = v - psum[s - hi - 1];
                end
                coef_model[s] = v;
            end
        end
        deg = (target_model > MAX_SUM) ? MAX_SUM : target_model;
        return coef_model[deg];
    endfunction

    // Idle cycles before the next transaction, with the odd stretch of back-to-back traffic.
    function automatic int draw_wait(inout int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm_left = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 11);
    endfunction

    // Sampling, checking and prediction at the rising edge.
    always @(posedge aclk) begin
        cycle_count = cycle_count + 1;
        s_hs_seen <= aresetn && s_tvalid && s_tready;
        m_hs_seen <= aresetn && m_tvalid && m_tready;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (way_count_queue.size() == 0) begin
                $error("way_count: unexpected result, actual %0h", m_tdata);
                error_count++;
            end else begin
                logic [COUNT_W-1:0] want;
                want = way_count_queue.pop_front();
                if (m_tdata !== want) begin
                    $error("way_count mismatch: expected %0h, actual %0h", want, m_tdata);
                    error_count++;
                end
            end
        end
        if (aresetn && s_tvalid && s_tready) begin
            items_sent++;
            if (s_tuser[0]) restarts_seen++;
            if (s_tdata[BOUND_W-1:0] > s_tdata[2*BOUND_W-1:BOUND_W]) empty_boxes++;
            way_count_queue.insert(way_count_queue.size(),
                                   fold_box_into_table(s_tdata[BOUND_W-1:0],
                                                       s_tdata[2*BOUND_W-1:BOUND_W],
                                                       s_tuser[0]));
        end
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Cycle limit of %0d reached with %0d results outstanding",
                     CYCLE_LIMIT, way_count_queue.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Input driver: presents queued boxes at the falling edge after a random gap.
    int src_gap  = 0;
    int src_calm = 0;
    always @(negedge aclk) begin
        logic      next_valid;
        box_item_t item;
        next_valid = 1'b0;
        if (aresetn) begin
            if (s_tvalid && !s_hs_seen) begin
                next_valid = 1'b1;
            end else if (src_gap > 0) begin
                src_gap--;
            end else if (box_queue.size() != 0) begin
                item      = box_queue.pop_front();
                s_tdata  <= {item.upper_bound, item.lower_bound};
                s_tuser  <= item.first_variable;
                next_valid = 1'b1;
                src_gap   = draw_wait(src_calm);
            end
        end
        s_tvalid <= next_valid;
    end

    // Result sink: stalls each result for a random number of cycles while it is offered.
    int sink_wait = 0;
    int sink_calm = 0;
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_hs_seen) sink_wait = draw_wait(sink_calm);
            else if (m_tvalid && sink_wait > 0) sink_wait--;
            m_tready <= (sink_wait == 0);
        end
    end

    task automatic add_box(input int lo, input int hi, input bit first);
        box_item_t item;
        item.lower_bound    = BOUND_W'(lo);
        item.upper_bound    = BOUND_W'(hi);
        item.first_variable = first;
        box_queue.insert(box_queue.size(), item);
        items_queued++;
    endtask

    // Block is idle once every box is sent and every result has come back.
    task automatic wait_idle();
        while (box_queue.size() != 0 || s_tvalid || way_count_queue.size() != 0)
            @(posedge aclk);
        repeat (IDLE_GAP) @(posedge aclk);
    endtask

    task automatic set_target(input int value);
        wait_idle();
        @(negedge aclk);
        cfg_wen      <= 1'b1;
        cfg_wdata    <= TARGET_W'(value);
        target_model = TARGET_W'(value);
        targets_used++;
        @(negedge aclk);
        cfg_wen <= 1'b0;
    endtask

    // One run of variables: mostly bounds that can reach the target, some wide boxes that
    // make the counts wrap, and some fully random noise.
    task automatic queue_sequence(input bit restart);
        int kind;
        int n;
        int budget;
        int lo;
        int hi;
        kind = $urandom_range(0, 9);
        if (kind >= 8) begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++)
                add_box($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 1));
        end else begin
            n      = (kind == 0) ? $urandom_range(8, 40) : $urandom_range(1, 12);
            budget = target_model / n;
            for (int i = 0; i < n; i++) begin
                if (kind == 0) begin
                    lo = $urandom_range(0, 2);
                    hi = lo + $urandom_range(100, 255);
                end else begin
                    lo = $urandom_range(0, budget);
                    hi = lo + $urandom_range(0, 2 * budget + 3);
                end
                if (hi > 255) hi = 255;
                if ($urandom_range(0, 39) == 0) begin
                    lo = $urandom_range(1, 255);
                    hi = $urandom_range(0, lo - 1);
                end
                add_box(lo, hi, (i == 0) && restart);
            end
        end
    endtask

    initial begin
        int directed_count;
        int phase;
        int t;
        int phase_end;
        for (int s = 0; s <= MAX_SUM; s++) coef_model[s] = '0;
        coef_model[0] = COUNT_W'(1);

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset target of zero, and no restart before the first variable.
        add_box(0, 0, 0);
        add_box(0, 255, 0);
        add_box(1, 1, 0);
        add_box(0, 0, 1);
        add_box(3, 2, 0);      // empty box clears the table
        add_box(0, 0, 0);      // stays zero until the next restart
        // Highest target with the extremes of the bounds.
        set_target(255);
        add_box(255, 255, 1);
        add_box(0, 0, 0);
        add_box(0, 255, 1);
        add_box(0, 255, 0);
        add_box(0, 255, 0);
        add_box(255, 0, 0);
        // A small target, then a new target in the middle of a run.
        set_target(10);
        add_box(2, 5, 1);
        add_box(0, 3, 0);
        add_box(1, 1, 0);
        set_target(7);
        add_box(0, 1, 0);
        set_target(200);
        add_box(170, 85, 1);   // restart on an empty box
        add_box(85, 170, 0);
        add_box(85, 170, 1);
        add_box(0, 170, 0);
        directed_count = items_queued;

        phase = 0;
        while (items_queued - directed_count < RANDOM_ITEMS) begin
            if (phase == 0) t = 255;
            else if (phase == 1) t = 0;
            else if ($urandom_range(0, 5) == 0) t = $urandom_range(0, 1) ? 255 : 0;
            else t = $urandom_range(0, 255);
            set_target(t);
            phase_end = items_queued + $urandom_range(60, 150);
            if (phase_end > directed_count + RANDOM_ITEMS)
                phase_end = directed_count + RANDOM_ITEMS;
            while (items_queued < phase_end) queue_sequence($urandom_range(0, 7) != 0);
            phase++;
        end

        wait_idle();
        repeat (2 * MAX_SUM + 5) @(posedge aclk);
        if (way_count_queue.size() != 0) begin
            $error("way_count: %0d expected results never arrived", way_count_queue.size());
            error_count++;
        end
        $display("Run covered %0d input transactions and %0d results over %0d target settings,",
                 items_sent, results_seen, targets_used);
        $display("with %0d restarts and %0d empty boxes.", restarts_seen, empty_boxes);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
